[hdl/sip_pkg.sv]
// Package for the string-to-integer parser core.
// Holds the item structs, phase enum, character codes and digit helpers.
// No dependencies.
package sip_pkg;

  localparam int VALUE_WIDTH_DEF    = 64;
  localparam int POSITION_WIDTH_DEF = 16;

  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] NO_DIGIT  = 6'd36;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] BASE_AUTO = 6'd0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_START,
    PH_ZERO,
    PH_ZEROX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [15:0]        consumed;
    logic               range_error;
  } out_item_t;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      t = c - CH_UP_A + 8'd10;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      t = c - CH_LO_A + 8'd10;
    end else begin
      t = {2'b00, NO_DIGIT};
    end
    return t[5:0];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

[hdl/string_to_integer_parser_core.sv]
// Top level of the string-to-integer parser core.
// Parses one character per item, strtol style; depends on sip_pkg.
//
// channel  direction  handshake            payload
// src      in         src_valid/src_stall  in_item_t  (ch, char_valid, last)
// res      out        res_valid/res_stall  out_item_t (value, consumed, range_error)
// radix    in         radix_we             radix_wdata (6 bits)
//
// One item per cycle while src_stall is low; the character step is one
// multiply-add and compare on the accumulator, computed combinationally. A result
// passes a snapshot register, then the output register with the sign applied.
// Synchronous reset clears the string state, the radix and both valid flags.
// src_stall rises only while both registers are full and res_stall is high.
module string_to_integer_parser_core
  import sip_pkg::*;
#(
  parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  in_item_t   src_item,
  output logic       res_valid,
  input  logic       res_stall,
  output out_item_t  res_item,
  input  logic       radix_we,
  input  logic [5:0] radix_wdata
);

  localparam int PROD_W = VALUE_WIDTH + 7;
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
  localparam logic [VALUE_WIDTH-1:0] MAG_HALF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [5:0]                radix;
  phase_t                    phase;
  logic                      negative;
  logic [5:0]                abase;
  logic [VALUE_WIDTH-1:0]    acc;
  logic [POSITION_WIDTH-1:0] pos;
  logic [POSITION_WIDTH-1:0] endp;
  logic                      sat;

  phase_t                    phase_next;
  logic                      negative_next;
  logic [5:0]                abase_next;
  logic [VALUE_WIDTH-1:0]    acc_next;
  logic [POSITION_WIDTH-1:0] pos_next;
  logic [POSITION_WIDTH-1:0] endp_next;
  logic                      sat_next;

  logic                      snap_valid;
  logic                      snap_neg;
  logic                      snap_sat;
  logic [VALUE_WIDTH-1:0]    snap_acc;
  logic [POSITION_WIDTH-1:0] snap_endp;

  logic accept;
  logic out_free;
  logic snap_free;

  logic [7:0]                c;
  logic [5:0]                d;
  logic [5:0]                rdx_eff;
  logic [5:0]                tb;
  logic                      take;
  logic                      skip;
  phase_t                    eph;
  logic [POSITION_WIDTH-1:0] after;
  logic [VALUE_WIDTH-1:0]    limit;
  logic [PROD_W-1:0]         prod;
  logic                      ovf;

  logic [VALUE_WIDTH-1:0]        mag;
  logic signed [VALUE_WIDTH-1:0] sval;
  logic [31:0]                   endx;

  assign out_free  = !res_valid || !res_stall;
  assign snap_free = !snap_valid || out_free;
  assign src_stall = !snap_free;
  assign accept    = src_valid && !src_stall;

  assign c       = src_item.ch;
  assign d       = digit_of(c);
  assign rdx_eff = (radix > RADIX_MAX) ? BASE_AUTO : radix;
  assign after   = (pos == POS_MAX) ? pos : pos + 1'b1;
  assign limit   = negative ? MAG_HALF : MAG_HALF - 1'b1;

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    abase_next    = abase;
    acc_next      = acc;
    pos_next      = pos;
    endp_next     = endp;
    sat_next      = sat;
    eph           = phase;
    take          = 1'b0;
    skip          = 1'b0;
    tb            = abase;
    prod          = '0;
    ovf           = 1'b0;
    if (src_item.char_valid) begin
      pos_next = after;
      if (phase == PH_SPACE) begin
        if (is_space(c)) begin
          skip = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          skip          = 1'b1;
          negative_next = (c == CH_MINUS);
          phase_next    = PH_START;
        end else begin
          eph = PH_START;
        end
      end
      if (!skip) begin
        unique case (eph)
          PH_START: begin
            abase_next = rdx_eff;
            if (c == CH_ZERO && (rdx_eff == BASE_AUTO || rdx_eff == BASE_HEX)) begin
              acc_next   = '0;
              endp_next  = after;
              phase_next = PH_ZERO;
            end else begin
              take       = 1'b1;
              tb         = (rdx_eff == BASE_AUTO) ? BASE_DEC : rdx_eff;
              abase_next = tb;
            end
          end
          PH_ZERO: begin
            if (c == CH_LO_X || c == CH_UP_X) begin
              phase_next = PH_ZEROX;
            end else begin
              take       = 1'b1;
              tb         = (abase != BASE_AUTO) ? abase :
                           (d < BASE_OCT) ? BASE_OCT : BASE_DEC;
              abase_next = tb;
            end
          end
          PH_ZEROX: begin
            if (d < BASE_HEX) begin
              take       = 1'b1;
              tb         = BASE_HEX;
              abase_next = BASE_HEX;
            end else begin
              phase_next = PH_DONE;
            end
          end
          PH_DIGITS: begin
            take = 1'b1;
            tb   = abase;
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase
      end
      if (take) begin
        prod = PROD_W'(acc) * PROD_W'(tb) + PROD_W'(d);
        ovf  = prod > PROD_W'(limit);
        if (d >= tb) begin
          phase_next = PH_DONE;
        end else begin
          endp_next = after;
          if (ovf) begin
            sat_next   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            acc_next   = prod[VALUE_WIDTH-1:0];
            phase_next = PH_DIGITS;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= BASE_AUTO;
      phase      <= PH_SPACE;
      negative   <= 1'b0;
      abase      <= BASE_AUTO;
      acc        <= '0;
      pos        <= '0;
      endp       <= '0;
      sat        <= 1'b0;
      snap_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (radix_we) begin
        radix <= radix_wdata;
      end
      if (accept) begin
        if (src_item.last) begin
          phase    <= PH_SPACE;
          negative <= 1'b0;
          abase    <= BASE_AUTO;
          acc      <= '0;
          pos      <= '0;
          endp     <= '0;
          sat      <= 1'b0;
        end else begin
          phase    <= phase_next;
          negative <= negative_next;
          abase    <= abase_next;
          acc      <= acc_next;
          pos      <= pos_next;
          endp     <= endp_next;
          sat      <= sat_next;
        end
      end
      if (accept && src_item.last) begin
        snap_valid <= 1'b1;
      end else if (out_free) begin
        snap_valid <= 1'b0;
      end
      if (out_free) begin
        res_valid <= snap_valid;
      end
    end
  end

  always_comb begin
    mag  = snap_sat ? (snap_neg ? MAG_HALF : MAG_HALF - 1'b1) : snap_acc;
    sval = snap_neg ? -mag : mag;
    endx = 32'(snap_endp);
  end

  always_ff @(posedge clk) begin
    if (accept && src_item.last) begin
      snap_neg  <= negative_next;
      snap_sat  <= sat_next;
      snap_acc  <= acc_next;
      snap_endp <= endp_next;
    end
    if (out_free && snap_valid) begin
      res_item.value       <= 64'(sval);
      res_item.consumed    <= (endx > 32'h0000FFFF) ? 16'hFFFF : endx[15:0];
      res_item.range_error <= snap_sat;
    end
  end

endmodule

[hdl/sip_checker.sv]
// Port-level checker for the string-to-integer parser core, with its bind.
// Depends on sip_pkg and string_to_integer_parser_core.
module sip_checker
  import sip_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  input logic      src_valid,
  input logic      src_stall,
  input in_item_t  src_item,
  input logic      res_valid,
  input logic      res_stall,
  input out_item_t res_item
);

  localparam logic [63:0] VMAX = {{(65-VALUE_WIDTH){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [63:0] VMIN = ~VMAX;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("result item changed while stalled");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.range_error |->
      (res_item.value == VMAX) || (res_item.value == VMIN))
    else $error("range error without a saturated value");

  a_value_consumed: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.value != 64'd0) |-> res_item.consumed != 16'd0)
    else $error("nonzero value with nothing consumed");

  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid || !res_stall |-> !src_stall)
    else $error("input stalled while output side is free");

endmodule

bind string_to_integer_parser_core sip_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_sip_checker (.*);

[tb/string_to_integer_parser_checker.sv]
// Checker for the string-to-integer parser core: watches the source, result and radix ports,
// predicts each result from the accepted characters and compares it field by field.
// Depends on sip_pkg for the item structs, phase enum and character codes.
`timescale 1ns / 100ps

module string_to_integer_parser_checker
  import sip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  input  logic       src_stall,
  input  in_item_t   src_item,
  input  logic       res_valid,
  input  logic       res_stall,
  input  out_item_t  res_item,
  input  logic       radix_we,
  input  logic [5:0] radix_wdata,
  output int         mismatches,
  output int         open_results
);

  localparam logic [63:0] MAG_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAG_NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [15:0] POS_SAT       = 16'hFFFF;

  out_item_t   expected_results[$];
  int          fail_count = 0;

  logic [5:0]  radix_reg;
  phase_t      scan_phase;
  logic        neg_sign;
  logic [5:0]  cur_base;
  logic [63:0] magnitude;
  logic [15:0] char_pos;
  logic [15:0] end_pos;
  logic        overflowed;

  function automatic logic [5:0] char_digit(input logic [7:0] c);
    logic [7:0] v;
    v = {2'b00, NO_DIGIT};
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      v = c - CH_UP_A + 8'd10;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      v = c - CH_LO_A + 8'd10;
    end
    return v[5:0];
  endfunction

  function automatic logic char_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic clear_string();
    scan_phase = PH_SPACE;
    neg_sign   = 1'b0;
    cur_base   = BASE_AUTO;
    magnitude  = '0;
    char_pos   = '0;
    end_pos    = '0;
    overflowed = 1'b0;
  endtask

  task automatic accept_digit(input logic [7:0] c, input logic [15:0] after);
    logic [5:0]  d;
    logic [63:0] b;
    logic [63:0] lim;
    d   = char_digit(c);
    b   = (cur_base != BASE_AUTO) ? {58'd0, cur_base} : {58'd0, BASE_DEC};
    lim = neg_sign ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
    if ({58'd0, d} >= b) begin
      scan_phase = PH_DONE;
    end else begin
      end_pos = after;
      if (magnitude > (lim - {58'd0, d}) / b) begin
        overflowed = 1'b1;
        scan_phase = PH_DONE;
      end else begin
        magnitude  = magnitude * b + {58'd0, d};
        scan_phase = PH_DIGITS;
      end
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [15:0] after;
    logic [5:0]  b;
    logic        skip;
    after = (char_pos != POS_SAT) ? char_pos + 16'd1 : POS_SAT;
    skip  = 1'b0;
    if (scan_phase == PH_SPACE) begin
      if (char_blank(c)) begin
        skip = 1'b1;
      end else begin
        scan_phase = PH_START;
        if (c == CH_MINUS || c == CH_PLUS) begin
          neg_sign = (c == CH_MINUS);
          skip     = 1'b1;
        end
      end
    end
    if (!skip) begin
      case (scan_phase)
        PH_START: begin
          b        = (radix_reg > RADIX_MAX) ? BASE_AUTO : radix_reg;
          cur_base = b;
          if (c == CH_ZERO && (b == BASE_AUTO || b == BASE_HEX)) begin
            magnitude  = '0;
            end_pos    = after;
            scan_phase = PH_ZERO;
          end else begin
            if (b == BASE_AUTO) cur_base = BASE_DEC;
            accept_digit(c, after);
          end
        end
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            scan_phase = PH_ZEROX;
          end else begin
            if (cur_base == BASE_AUTO) cur_base = (char_digit(c) < BASE_OCT) ? BASE_OCT : BASE_DEC;
            accept_digit(c, after);
          end
        end
        PH_ZEROX: begin
          if (char_digit(c) < BASE_HEX) begin
            cur_base  = BASE_HEX;
            magnitude = '0;
            accept_digit(c, after);
          end else begin
            scan_phase = PH_DONE;
          end
        end
        PH_DIGITS: accept_digit(c, after);
        default:   scan_phase = PH_DONE;
      endcase
    end
    char_pos = after;
  endtask

  task automatic finish_string();
    out_item_t want;
    if (overflowed) begin
      want.value = neg_sign ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
    end else begin
      want.value = neg_sign ? -magnitude : magnitude;
    end
    want.consumed    = end_pos;
    want.range_error = overflowed;
    expected_results.push_back(want);
    clear_string();
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing expected: value %0d consumed %0d range_error %0b",
               $time, $signed(got.value), got.consumed, got.range_error);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value mismatch: expected %0d, actual %0d",
                 $time, $signed(want.value), $signed(got.value));
        fail_count++;
      end
      if (got.consumed !== want.consumed) begin
        $display("%0t: consumed mismatch: expected %0d, actual %0d",
                 $time, want.consumed, got.consumed);
        fail_count++;
      end
      if (got.range_error !== want.range_error) begin
        $display("%0t: range_error mismatch: expected %0b, actual %0b",
                 $time, want.range_error, got.range_error);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      radix_reg = BASE_AUTO;
      clear_string();
      expected_results.delete();
    end else begin
      if (src_valid && !src_stall) begin
        if (src_item.char_valid) parse_char(src_item.ch);
        if (src_item.last) finish_string();
      end
      if (radix_we) radix_reg = radix_wdata;
      if (res_valid && !res_stall) check_result(res_item);
    end
    open_results <= expected_results.size();
    mismatches   <= fail_count;
  end

endmodule

[tb/string_to_integer_parser_core_tb.sv]
// Testbench top for the string-to-integer parser core: drives character strings and radix
// settings with random gaps and result stalls, and reports the verdict.
// Depends on sip_pkg, string_to_integer_parser_core and string_to_integer_parser_checker.
`timescale 1ns / 100ps

module string_to_integer_parser_core_tb;
  import sip_pkg::*;

  localparam int PHASE_ITEMS = 70;
  localparam int NUM_PHASES  = 12;
  localparam int LONG_ZEROS  = 40;

  logic       clk;
  logic       rst;
  logic       src_valid;
  logic       src_stall;
  in_item_t   src_item;
  logic       res_valid;
  logic       res_stall;
  out_item_t  res_item;
  logic       radix_we;
  logic [5:0] radix_wdata;
  int         mismatches;
  int         open_results;

  in_item_t   string_buf[$];
  int         items_sent   = 0;
  int         cur_radix    = 0;
  bit         holdoff_go   = 1'b0;
  bit         holdoff_done = 1'b0;
  int         radix_plan[10] = '{0, 10, 16, 8, 2, 36, 1, 63, 37, 5};

  string_to_integer_parser_core dut (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .src_item    (src_item),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_item    (res_item),
    .radix_we    (radix_we),
    .radix_wdata (radix_wdata)
  );

  string_to_integer_parser_checker chk (
    .clk          (clk),
    .rst          (rst),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .src_item     (src_item),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res_item     (res_item),
    .radix_we     (radix_we),
    .radix_wdata  (radix_wdata),
    .mismatches   (mismatches),
    .open_results (open_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] digit_char(input int d, input bit upper);
    if (d < 10) return CH_ZERO + 8'(d);
    return (upper ? CH_UP_A : CH_LO_A) + 8'(d - 10);
  endfunction

  task automatic add_raw(input logic [7:0] c, input logic cv, input logic lst);
    in_item_t it;
    it.ch         = c;
    it.char_valid = cv;
    it.last       = lst;
    string_buf.push_back(it);
  endtask

  task automatic add_char(input logic [7:0] c);
    if ($urandom_range(0, 19) == 0) add_raw(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    add_raw(c, 1'b1, 1'b0);
  endtask

  task automatic add_prefix_hex();
    add_char(CH_ZERO);
    add_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
  endtask

  task automatic add_lead();
    int n;
    int r;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) begin
      r = $urandom_range(0, 5);
      add_char(r == 0 ? CH_SPACE : CH_TAB + 8'(r - 1));
    end
    r = $urandom_range(0, 2);
    if (r == 1) add_char(CH_PLUS);
    if (r == 2) add_char(CH_MINUS);
  endtask

  task automatic add_value(input logic [63:0] v, input int b);
    logic [7:0] digs[$];
    do begin
      digs.push_front(digit_char(int'(v % b), $urandom_range(0, 1)));
      v = v / b;
    end while (v != 0);
    foreach (digs[i]) add_char(digs[i]);
  endtask

  task automatic gen_number(input int eff);
    int b;
    int n;
    int d;
    add_lead();
    b = eff;
    if (b == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          add_prefix_hex();
          b = 16;
        end
        1: begin
          add_char(CH_ZERO);
          b = 8;
        end
        default: b = 10;
      endcase
    end
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 24);
    repeat (n) begin
      d = ($urandom_range(0, 9) != 0) ? $urandom_range(0, b - 1) : $urandom_range(0, 35);
      add_char(digit_char(d, $urandom_range(0, 1)));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic gen_extreme(input int eff);
    logic [63:0] v;
    int          b;
    add_lead();
    b = eff;
    if (b == 0) begin
      if ($urandom_range(0, 1)) begin
        add_prefix_hex();
        b = 16;
      end else begin
        b = 10;
      end
    end
    case ($urandom_range(0, 5))
      0: v = 64'h7FFF_FFFF_FFFF_FFFF;
      1: v = 64'h8000_0000_0000_0000;
      2: v = 64'h8000_0000_0000_0001;
      3: v = 64'hFFFF_FFFF_FFFF_FFFF;
      4: v = {2'b01, 30'($urandom), $urandom};
      default: v = {1'b1, 31'($urandom), $urandom};
    endcase
    add_value(v, b);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) add_char(digit_char($urandom_range(0, b - 1), 1'b0));
    end
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6)) begin
      add_raw(8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0, 1'b0);
    end
  endtask

  task automatic close_string();
    in_item_t it;
    if (string_buf.size() == 0 || $urandom_range(0, 4) == 0) begin
      add_raw(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else begin
      it      = string_buf.pop_back();
      it.last = 1'b1;
      string_buf.push_back(it);
    end
  endtask

  task automatic make_random_string();
    int eff;
    int r;
    eff = (cur_radix > 36) ? 0 : cur_radix;
    r   = $urandom_range(0, 99);
    if (r < 65 || (r < 80 && eff == 1)) begin
      gen_number(eff);
    end else if (r < 80) begin
      gen_extreme(eff);
    end else begin
      gen_noise();
    end
    close_string();
  endtask

  task automatic drive_item(input in_item_t it, input bit gapless);
    int gap;
    int r;
    src_item  <= it;
    src_valid <= 1'b1;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    if (it.char_valid || it.last) items_sent++;
    gap = 0;
    if (!gapless) begin
      r = $urandom_range(0, 99);
      if (r >= 97) gap = $urandom_range(20, 60);
      else if (r >= 85) gap = $urandom_range(4, 12);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_string(input bit gapless_in);
    bit gapless;
    gapless = gapless_in || ($urandom_range(0, 3) == 0);
    foreach (string_buf[i]) drive_item(string_buf[i], gapless);
    string_buf.delete();
  endtask

  task automatic write_radix(input int v);
    radix_wdata <= 6'(v);
    radix_we    <= 1'b1;
    @(posedge clk);
    radix_we    <= 1'b0;
    cur_radix = v;
  endtask

  task automatic wait_idle();
    src_valid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    int r;
    int n;
    res_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holdoff_go && !holdoff_done) begin
        res_stall <= 1'b1;
        repeat (400) @(posedge clk);
        holdoff_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          res_stall <= 1'b0;
          n = $urandom_range(1, 30);
        end else begin
          res_stall <= 1'b1;
          if (r < 85) n = $urandom_range(1, 3);
          else if (r < 97) n = $urandom_range(4, 20);
          else n = $urandom_range(30, 80);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int p;
    int phase_start;
    rst         <= 1'b1;
    src_valid   <= 1'b0;
    src_item    <= '0;
    radix_we    <= 1'b0;
    radix_wdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_radix(0);
    add_raw(8'h00, 1'b0, 1'b1);
    add_raw(CH_CR, 1'b1, 1'b0);
    add_raw(CH_MINUS, 1'b1, 1'b1);
    add_raw(CH_ZERO, 1'b1, 1'b0);
    add_raw(CH_LO_X, 1'b1, 1'b0);
    add_raw(CH_LO_A + 8'd6, 1'b1, 1'b1);
    add_raw(CH_ZERO, 1'b1, 1'b0);
    add_raw(CH_ZERO + 8'd8, 1'b1, 1'b1);
    add_raw(CH_SPACE, 1'b1, 1'b0);
    add_raw(CH_ZERO, 1'b1, 1'b0);
    add_raw(CH_UP_X, 1'b1, 1'b0);
    add_raw(CH_ZERO + 8'd1, 1'b1, 1'b0);
    add_raw(CH_UP_A + 8'd5, 1'b1, 1'b1);
    add_raw(CH_MINUS, 1'b1, 1'b0);
    add_raw(CH_ZERO, 1'b1, 1'b0);
    add_raw(CH_ZERO + 8'd1, 1'b1, 1'b0);
    add_raw(CH_ZERO + 8'd7, 1'b1, 1'b1);
    add_raw(8'hFF, 1'b1, 1'b1);
    add_raw(8'h5A, 1'b0, 1'b0);
    add_raw(CH_PLUS, 1'b1, 1'b0);
    add_raw(CH_NINE, 1'b1, 1'b1);
    add_raw(CH_LO_Z, 1'b1, 1'b1);
    add_raw(8'h00, 1'b1, 1'b1);
    send_string(1'b0);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_radix(p < 10 ? radix_plan[p] : $urandom_range(0, 63));
      if (p == 2) holdoff_go = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        make_random_string();
        send_string(1'b0);
      end
    end

    // drive a long run of leading zeros
    wait_idle();
    write_radix(0);
    repeat (LONG_ZEROS) add_raw(CH_ZERO, 1'b1, 1'b0);
    add_raw(CH_ZERO + 8'd7, 1'b1, 1'b1);
    send_string(1'b1);
    wait_idle();

    if (mismatches == 0 && open_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
